### rtl/swk_pkg.sv
package swk_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_N     = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int STEP_W       = 5;
  localparam int ROOT_TOP     = 16;
  localparam int CFG_AW       = 4;

  localparam logic [15:0] HALF_RESET    = 16'd3712;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  localparam logic [1:0] REG_HALF_LENGTH = 2'd0;
  localparam logic [1:0] REG_HALF_WIDTH  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT     = 2'd2;

  typedef struct packed {
    logic               active;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] turn_rate;
    logic [15:0]        command_age_ms;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        fl_speed;
    logic [15:0]        fr_speed;
    logic [15:0]        rl_speed;
    logic [15:0]        rr_speed;
    logic signed [15:0] fl_angle;
    logic signed [15:0] fr_angle;
    logic signed [15:0] rl_angle;
    logic signed [15:0] rr_angle;
    logic               angles_valid;
  } out_word_t;

  typedef struct packed {
    logic [15:0] half_length;
    logic [15:0] half_width;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MULA, OP_MULB, OP_SAT, OP_SQ1, OP_SQ2, OP_ROOT,
    OP_RND, OP_CINIT, OP_CSTEP, OP_CRND, OP_PUB, OP_PUBZ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [1:0]        pair;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MULA, S_MULB, S_SAT, S_SQ1, S_SQ2, S_ROOT, S_RND,
    S_CINIT, S_CSTEP, S_CRND, S_DONE, S_HALT
  } state_t;

  function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
    logic signed [15:0] r;
    if (v > 26'sd32767) r = 16'sh7FFF;
    else if (v < -26'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic [31:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/swk_in_if.sv
interface swk_in_if;
  import swk_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/swk_out_if.sv
interface swk_out_if;
  import swk_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/swk_ctrl.sv
module swk_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_active,
  output logic           in_ready,
  input  logic           out_ready,
  output logic           out_valid,
  output swk_pkg::cmd_t  cmd
);
  import swk_pkg::*;

  state_t            state_r, state_nxt;
  logic [1:0]        pair_r, pair_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              halted_r, halted_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              can_pub;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pair_r      <= '0;
      step_r      <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pair_r      <= pair_nxt;
      step_r      <= step_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign can_pub = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    pair_nxt      = pair_r;
    step_nxt      = step_r;
    halted_nxt    = halted_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.pair      = pair_r;
    cmd.step      = step_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_active) begin
            halted_nxt = 1'b0;
            cmd.op     = OP_LOAD;
            state_nxt  = S_MULA;
          end else if (!halted_r) begin
            halted_nxt = 1'b1;
            state_nxt  = S_HALT;
          end
        end
      end
      S_MULA: begin
        cmd.op    = OP_MULA;
        state_nxt = S_MULB;
      end
      S_MULB: begin
        cmd.op    = OP_MULB;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        cmd.op    = OP_SAT;
        pair_nxt  = '0;
        state_nxt = S_SQ1;
      end
      S_SQ1: begin
        cmd.op    = OP_SQ1;
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        cmd.op    = OP_SQ2;
        step_nxt  = STEP_W'(ROOT_TOP);
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.op = OP_ROOT;
        if (step_r == '0) state_nxt = S_RND;
        else step_nxt = step_r - 1'b1;
      end
      S_RND: begin
        cmd.op    = OP_RND;
        state_nxt = S_CINIT;
      end
      S_CINIT: begin
        cmd.op    = OP_CINIT;
        step_nxt  = '0;
        state_nxt = S_CSTEP;
      end
      S_CSTEP: begin
        cmd.op = OP_CSTEP;
        if (step_r == STEP_W'(CORDIC_N - 1)) state_nxt = S_CRND;
        else step_nxt = step_r + 1'b1;
      end
      S_CRND: begin
        cmd.op = OP_CRND;
        if (pair_r == 2'd3) begin
          state_nxt = S_DONE;
        end else begin
          pair_nxt  = pair_r + 1'b1;
          state_nxt = S_SQ1;
        end
      end
      S_DONE: begin
        if (can_pub) begin
          cmd.op        = OP_PUB;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_HALT: begin
        if (can_pub) begin
          cmd.op        = OP_PUBZ;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_halt_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HALT) |-> halted_r)
    else $error("halt result pending while not halted");
  a_active_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_active) |=> (state_r == S_MULA && !halted_r))
    else $error("active word did not start work");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CSTEP) |-> (step_r < STEP_W'(CORDIC_N)))
    else $error("cordic step out of range");
  a_pub_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PUB || cmd.op == OP_PUBZ) |=> out_valid)
    else $error("published result not valid");
`endif
endmodule

### rtl/swk_dp.sv
module swk_dp (
  input  logic                clk,
  input  swk_pkg::cmd_t       cmd,
  input  swk_pkg::cfg_t       cfg,
  input  swk_pkg::in_word_t   in_data,
  output swk_pkg::out_word_t  out_data
);
  import swk_pkg::*;

  logic signed [15:0] vx_r, vy_r, w_r;
  logic signed [32:0] prod_r;
  logic signed [24:0] ta_r;
  logic signed [15:0] a_r, b_r, c_r, d_r;
  logic [31:0]        sq_r, n_r;
  logic [16:0]        r_r;
  logic signed [27:0] xs_r, ys_r;
  logic [31:0]        z_r;
  logic               zero_r;
  logic [15:0]        spd_r [4];
  logic [15:0]        ang_r [4];
  out_word_t          out_r;

  logic               stale;
  logic signed [32:0] prod_rnd;
  logic signed [24:0] scaled;
  logic signed [25:0] vx_e, vy_e, ta_e, tb_e;
  logic signed [15:0] p, q;
  logic signed [31:0] pp, qq;
  logic [16:0]        t;
  logic [33:0]        tt, rr;
  logic signed [27:0] xi, yi, dx, dy;
  logic [31:0]        zr;

  assign stale    = in_data.command_age_ms > cfg.timeout_ms;
  assign prod_rnd = prod_r + 33'sd128;
  assign scaled   = prod_rnd[32:8];
  assign vx_e     = {{10{vx_r[15]}}, vx_r};
  assign vy_e     = {{10{vy_r[15]}}, vy_r};
  assign ta_e     = {ta_r[24], ta_r};
  assign tb_e     = {scaled[24], scaled};
  assign p        = cmd.pair[1] ? a_r : b_r;
  assign q        = cmd.pair[0] ? c_r : d_r;
  assign pp       = p * p;
  assign qq       = q * q;
  assign t        = r_r | (17'd1 << cmd.step);
  assign tt       = {17'd0, t} * {17'd0, t};
  assign rr       = {17'd0, r_r} * {17'd0, r_r};
  assign xi       = {{4{q[15]}}, q, 8'd0};
  assign yi       = {{4{p[15]}}, p, 8'd0};
  assign dx       = ys_r >>> cmd.step;
  assign dy       = xs_r >>> cmd.step;
  assign zr       = z_r + 32'h0000_8000;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        vx_r <= stale ? 16'sd0 : in_data.vel_x;
        vy_r <= in_data.vel_y;
        w_r  <= stale ? 16'sd0 : in_data.turn_rate;
      end
      OP_MULA: prod_r <= w_r * $signed({1'b0, cfg.half_length});
      OP_MULB: begin
        ta_r   <= scaled;
        prod_r <= w_r * $signed({1'b0, cfg.half_width});
      end
      OP_SAT: begin
        a_r <= sat16(vx_e - ta_e);
        b_r <= sat16(vx_e + ta_e);
        c_r <= sat16(vy_e - tb_e);
        d_r <= sat16(vy_e + tb_e);
      end
      OP_SQ1: sq_r <= $unsigned(pp);
      OP_SQ2: begin
        n_r <= sq_r + $unsigned(qq);
        r_r <= '0;
      end
      OP_ROOT: if (tt <= {2'd0, n_r}) r_r <= t;
      OP_RND: begin
        if (({2'd0, n_r} - rr) > {17'd0, r_r}) spd_r[cmd.pair] <= r_r[15:0] + 16'd1;
        else spd_r[cmd.pair] <= r_r[15:0];
      end
      OP_CINIT: begin
        zero_r <= (p == 16'sd0) && (q == 16'sd0);
        if (q < 16'sd0) begin
          xs_r <= -xi;
          ys_r <= -yi;
          z_r  <= 32'h8000_0000;
        end else begin
          xs_r <= xi;
          ys_r <= yi;
          z_r  <= '0;
        end
      end
      OP_CSTEP: begin
        if (ys_r < 28'sd0) begin
          xs_r <= xs_r - dx;
          ys_r <= ys_r + dy;
          z_r  <= z_r - atan_lut(cmd.step);
        end else begin
          xs_r <= xs_r + dx;
          ys_r <= ys_r - dy;
          z_r  <= z_r + atan_lut(cmd.step);
        end
      end
      OP_CRND: ang_r[cmd.pair] <= zero_r ? 16'd0 : zr[31:16];
      OP_PUB: begin
        out_r.fl_speed     <= spd_r[0];
        out_r.fr_speed     <= spd_r[1];
        out_r.rl_speed     <= spd_r[2];
        out_r.rr_speed     <= spd_r[3];
        out_r.fl_angle     <= ang_r[0];
        out_r.fr_angle     <= ang_r[1];
        out_r.rl_angle     <= ang_r[2];
        out_r.rr_angle     <= ang_r[3];
        out_r.angles_valid <= 1'b1;
      end
      OP_PUBZ: out_r <= '0;
      default: ;
    endcase
  end

  assign out_data = out_r;
endmodule

### rtl/swerve_wheel_kinematics.sv
// Swerve wheel kinematics: one chassis command word in, one wheel result word out.
// A shared square-root and CORDIC unit handles the four wheels in turn; a new word
//   is taken only in idle, once the last result has gone to the output register.
// An inactive word gives a zero result; further inactive words while halted give none.
// Reset (rst_n low, synchronous): idle, not halted, no result pending,
//   half sizes 3712, timeout 500.
module swerve_wheel_kinematics (
  input  logic                      clk,
  input  logic                      rst_n,
  swk_in_if.sink                    in_ch,
  swk_out_if.source                 out_ch,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [swk_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  import swk_pkg::*;

  cfg_t  cfg_r;
  cmd_t  cmd;
  logic  cfg_we;
  logic [1:0] cfg_idx;

  // APB: always ready; write lands on the access cycle.
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_length <= HALF_RESET;
      cfg_r.half_width  <= HALF_RESET;
      cfg_r.timeout_ms  <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_HALF_LENGTH: cfg_r.half_length <= cfg_pwdata[15:0];
        REG_HALF_WIDTH:  cfg_r.half_width  <= cfg_pwdata[15:0];
        REG_TIMEOUT:     cfg_r.timeout_ms  <= cfg_pwdata[15:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // Read back the addressed register; unmapped reads return zero.
  always_comb begin
    case (cfg_idx)
      REG_HALF_LENGTH: cfg_prdata = {16'd0, cfg_r.half_length};
      REG_HALF_WIDTH:  cfg_prdata = {16'd0, cfg_r.half_width};
      REG_TIMEOUT:     cfg_prdata = {16'd0, cfg_r.timeout_ms};
      default:         cfg_prdata = '0;
    endcase
  end

  // Sequencer: owns the halted flag, handshakes and the per-wheel step order.
  swk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_active (in_ch.data.active),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  // Datapath: products, saturation, shared root and CORDIC, output register.
  swk_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .cfg      (cfg_r),
    .in_data  (in_ch.data),
    .out_data (out_ch.data)
  );
endmodule

### sim/swerve_wheel_kinematics_tb.sv
module swerve_wheel_kinematics_tb;
  import swk_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Configuration port, idle until reset is released.
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  swk_in_if  cmd_ch ();
  swk_out_if whl_ch ();

  swerve_wheel_kinematics dut (
    .clk(clk), .rst_n(rst_n), .in_ch(cmd_ch.sink), .out_ch(whl_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  localparam int  CMD_LATENCY = 160;
  localparam longint CYCLE_LIMIT = 6000000;

  // Predictor state: chassis geometry, timeout and the halt latch.
  logic [15:0] pr_half_len, pr_half_wid, pr_timeout;
  bit          pr_halted;

  in_word_t  cmd_pending[$];
  out_word_t wheel_expect[$];
  int        fail_count = 0;
  int        words_sent = 0;
  int        words_got = 0;
  int        halt_words = 0;
  int        stale_words = 0;
  longint    cycle_count = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, words_got);
    fail_count++;
  endtask

  function automatic longint floor_shift(input longint v, input int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Rounded integer root of p^2+q^2.
  function automatic logic [15:0] wheel_speed(input longint p, input longint q);
    longint unsigned n, r, t;
    n = p * p + q * q;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    if (n - r * r > r) r++;
    return r[15:0];
  endfunction

  // Vectoring CORDIC for atan2(y, x), binary angle, 2^31 = pi before rounding.
  function automatic logic [15:0] steer_angle(input longint y, input longint x);
    longint xs, ys, dx, dy;
    logic [31:0] z;
    xs = x * 256;
    ys = y * 256;
    z = 32'd0;
    if (x == 0 && y == 0) return 16'd0;
    if (xs < 0) begin
      xs = -xs;
      ys = -ys;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = floor_shift(ys, i);
      dy = floor_shift(xs, i);
      if (ys < 0) begin
        xs -= dx; ys += dy; z -= atan_lut(i[STEP_W-1:0]);
      end else begin
        xs += dx; ys -= dy; z += atan_lut(i[STEP_W-1:0]);
      end
    end
    z += 32'h8000;
    return z[31:16];
  endfunction

  // Work out the wheel word for one accepted command; queue nothing for an inactive command while already halted.
  task automatic predict_wheels(input in_word_t c);
    longint vx, vy, w, ta, tb, a, b, cc, d;
    out_word_t r;
    r = '0;
    if (!c.active) begin
      if (!pr_halted) wheel_expect.insert(wheel_expect.size(), r);
      pr_halted = 1'b1;
      return;
    end
    pr_halted = 1'b0;
    vx = c.vel_x;
    vy = c.vel_y;
    w  = c.turn_rate;
    if (c.command_age_ms > pr_timeout) begin
      vx = 0;
      w = 0;
    end
    ta = floor_shift(w * longint'(pr_half_len) + 128, 8);
    tb = floor_shift(w * longint'(pr_half_wid) + 128, 8);
    a  = clamp16(vx - ta);
    b  = clamp16(vx + ta);
    cc = clamp16(vy - tb);
    d  = clamp16(vy + tb);
    r.fl_speed = wheel_speed(b, d);
    r.fr_speed = wheel_speed(b, cc);
    r.rl_speed = wheel_speed(a, d);
    r.rr_speed = wheel_speed(a, cc);
    r.fl_angle = steer_angle(b, d);
    r.fr_angle = steer_angle(b, cc);
    r.rl_angle = steer_angle(a, d);
    r.rr_angle = steer_angle(a, cc);
    r.angles_valid = 1'b1;
    wheel_expect.insert(wheel_expect.size(), r);
  endtask

  // Append one command to the stimulus queue.
  task automatic queue_cmd(input in_word_t c);
    cmd_pending.insert(cmd_pending.size(), c);
  endtask

  // Driver: bursts of words with random gaps, fed from cmd_pending.
  int burst_left = 0;
  int gap_left = 0;
  bit hold_drain = 1'b0;

  // Input handshake seen at the rising edge, consumed at the next falling edge.
  bit in_hs = 1'b0;

  always @(posedge clk) in_hs = rst_n && cmd_ch.valid && cmd_ch.ready;

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_hs) begin
        // Word was taken at the last rising edge: predict and advance.
        predict_wheels(cmd_ch.data);
        if (!cmd_ch.data.active) halt_words++;
        else if (cmd_ch.data.command_age_ms > pr_timeout) stale_words++;
        void'(cmd_pending.pop_front());
        words_sent++;
      end
      if (!(cmd_ch.valid && !in_hs)) begin
        if (gap_left > 0) gap_left--;
        if (cmd_pending.size() != 0 && gap_left == 0 && !hold_drain) begin
          cmd_ch.valid <= 1'b1;
          cmd_ch.data  <= cmd_pending[0];
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
          end
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls on its own pattern: long ready runs, then random stall runs.
  int stall_left = 0;
  int run_left = 0;

  initial whl_ch.ready = 1'b0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (run_left > 0) begin
        run_left--;
        whl_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        whl_ch.ready <= 1'b0;
      end else begin
        run_left = $urandom_range(0, 400);
        stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 200) : 0;
        whl_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: compare each accepted wheel word with the oldest expectation.
  always @(posedge clk) begin
    out_word_t g, e;
    if (rst_n && whl_ch.valid && whl_ch.ready) begin
      g = whl_ch.data;
      words_got++;
      if (wheel_expect.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        e = wheel_expect.pop_front();
        if (g.fl_speed != e.fl_speed) report("fl_speed", g.fl_speed, e.fl_speed);
        if (g.fr_speed != e.fr_speed) report("fr_speed", g.fr_speed, e.fr_speed);
        if (g.rl_speed != e.rl_speed) report("rl_speed", g.rl_speed, e.rl_speed);
        if (g.rr_speed != e.rr_speed) report("rr_speed", g.rr_speed, e.rr_speed);
        if (g.fl_angle != e.fl_angle) report("fl_angle", g.fl_angle, e.fl_angle);
        if (g.fr_angle != e.fr_angle) report("fr_angle", g.fr_angle, e.fr_angle);
        if (g.rl_angle != e.rl_angle) report("rl_angle", g.rl_angle, e.rl_angle);
        if (g.rr_angle != e.rr_angle) report("rr_angle", g.rr_angle, e.rr_angle);
        if (g.angles_valid != e.angles_valid)
          report("angles_valid", g.angles_valid, e.angles_valid);
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic in_word_t make_cmd(input bit act, input logic [15:0] vx,
                                        input logic [15:0] vy, input logic [15:0] w,
                                        input logic [15:0] age);
    in_word_t c;
    c.active = act;
    c.vel_x = vx;
    c.vel_y = vy;
    c.turn_rate = w;
    c.command_age_ms = age;
    return c;
  endfunction

  // Random speed: mostly moderate, sometimes zero, extreme or fully random bits.
  function automatic logic [15:0] rand_speed();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
      2: return 16'd0;
      default: return 16'($signed($urandom_range(0, 4096)) - 2048);
    endcase
  endfunction

  function automatic in_word_t rand_cmd();
    logic [15:0] age;
    age = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
    return make_cmd($urandom_range(0, 9) != 0, rand_speed(), rand_speed(),
                    rand_speed(), age);
  endfunction

  // Write one register over APB; the block must be idle.
  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'({idx, 2'b00});
    cfg_pwdata <= {16'($urandom_range(0, 65535)), val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_HALF_LENGTH: pr_half_len = val;
      REG_HALF_WIDTH:  pr_half_wid = val;
      REG_TIMEOUT:     pr_timeout  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Hold until the queue of commands and of expected words is empty and no word is
  // offered, then let the block settle.
  task automatic drain();
    while (cmd_pending.size() != 0 || cmd_ch.valid || wheel_expect.size() != 0)
      @(posedge clk);
    repeat (CMD_LATENCY) @(posedge clk);
  endtask

  initial begin
    static logic [15:0] hl_set[5] = '{16'd3712, 16'd0, 16'hFFFF, 16'd256, 16'd0};
    static logic [15:0] hw_set[5] = '{16'd3712, 16'hFFFF, 16'd0, 16'd9000, 16'd0};
    static logic [15:0] to_set[5] = '{16'd500, 16'd0, 16'hFFFF, 16'd100, 16'd300};
    pr_half_len = HALF_RESET;
    pr_half_wid = HALF_RESET;
    pr_timeout = TIMEOUT_RESET;
    pr_halted = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero vector, pure axes, extremes, stale command, halt pair, pi.
    queue_cmd(make_cmd(1, 16'd0, 16'd0, 16'd0, 16'd0));
    queue_cmd(make_cmd(1, 16'd256, 16'd0, 16'd0, 16'd0));
    queue_cmd(make_cmd(1, 16'd0, 16'd256, 16'd0, 16'd0));
    queue_cmd(make_cmd(1, 16'd0, 16'hFF00, 16'd0, 16'd0));
    queue_cmd(make_cmd(1, 16'hFF00, 16'd0, 16'd0, 16'd0));
    queue_cmd(make_cmd(1, 16'd0, 16'd0, 16'd256, 16'd0));
    queue_cmd(make_cmd(1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd500));
    queue_cmd(make_cmd(1, 16'h8000, 16'h8000, 16'h8000, 16'd0));
    queue_cmd(make_cmd(1, 16'h7FFF, 16'h8000, 16'h8000, 16'd0));
    queue_cmd(make_cmd(1, 16'h8000, 16'h7FFF, 16'h7FFF, 16'd0));
    queue_cmd(make_cmd(1, 16'd1000, 16'd300, 16'd500, 16'd501));
    queue_cmd(make_cmd(1, 16'd1000, 16'd300, 16'd500, 16'hFFFF));
    queue_cmd(make_cmd(0, 16'd1000, 16'd300, 16'd500, 16'd0));
    queue_cmd(make_cmd(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    queue_cmd(make_cmd(1, 16'd5, 16'd7, 16'hFFFD, 16'd0));
    queue_cmd(make_cmd(0, 16'd0, 16'd0, 16'd0, 16'd0));
    queue_cmd(make_cmd(1, 16'd0, 16'hFFFF, 16'd0, 16'd0));
    drain();

    // Random phases, each under its own chassis geometry and timeout.
    for (int ph = 0; ph < 5; ph++) begin
      if (ph != 0) begin
        cfg_write(REG_HALF_LENGTH, ph == 4 ? 16'($urandom) : hl_set[ph]);
        cfg_write(REG_HALF_WIDTH,  ph == 4 ? 16'($urandom) : hw_set[ph]);
        cfg_write(REG_TIMEOUT,     to_set[ph]);
      end
      for (int k = 0; k < 366; k++) queue_cmd(rand_cmd());
      if (ph == 2) begin
        // Pause the sender midway until every expected word is back.
        while (cmd_pending.size() > 180) @(posedge clk);
        hold_drain = 1'b1;
        while (cmd_ch.valid || wheel_expect.size() != 0) @(posedge clk);
        hold_drain = 1'b0;
      end
      drain();
    end

    $display("sent %0d command words (%0d halt, %0d stale), checked %0d wheel words",
             words_sent, halt_words, stale_words, words_got);
    $display("covered five geometry/timeout settings including zero and full-scale");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
